// ----- src/pkfc_pkg.sv -----
// shared types, constants and the crc-8 byte step for the key frame sender
package pkfc_pkg;

  localparam int unsigned TickW    = 17;
  localparam int unsigned PeriodW  = 16;
  localparam int unsigned KeyW     = 12;
  localparam int unsigned FrameLen = 5;
  localparam int unsigned IdxW     = $clog2(FrameLen);

  localparam logic [TickW-1:0]   TickMax      = '1;
  localparam logic [PeriodW-1:0] SendPeriodRst = 16'd100;
  localparam logic [7:0]         CrcPoly      = 8'h07;
  localparam logic [7:0]         CrcInit      = 8'h00;
  localparam logic [1:0]         KeyFixed     = 2'b01;

  typedef enum logic [1:0] {
    REG_START_BYTE  = 2'd0,
    REG_DEVICE_ID   = 2'd1,
    REG_SEND_PERIOD = 2'd2,
    REG_UNUSED      = 2'd3
  } reg_idx_t;

  typedef enum logic [IdxW-1:0] {
    POS_START = 3'd0,
    POS_DEV   = 3'd1,
    POS_KEY1  = 3'd2,
    POS_KEY2  = 3'd3,
    POS_CRC   = 3'd4
  } frame_pos_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] device_id;
    logic [7:0] key_one;
    logic [7:0] key_two;
  } frame_t;

  // one byte through the msb-first crc-8, polynomial 0x07
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

// ----- src/pkfc_tick.sv -----
// tick input register, saturating tick counter and frame assembly
module pkfc_tick import pkfc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [KeyW-1:0]    in_keys,
  input  logic [7:0]         start_byte,
  input  logic [7:0]         device_id,
  input  logic [PeriodW-1:0] send_period,
  output logic               ld_valid,
  input  logic               ld_ready,
  output frame_t             ld_frame
);

  logic              in_vld_r, in_vld_nxt;
  logic [KeyW-1:0]   keys_r;
  logic [TickW-1:0]  ticks_r, ticks_nxt, ticks_inc;
  logic              send, advance;

  assign ticks_inc = (ticks_r == TickMax) ? ticks_r : ticks_r + TickW'(1);
  assign send      = ticks_inc > {1'b0, send_period};
  assign advance   = in_vld_r && (!send || ld_ready);
  assign in_tready = !in_vld_r || advance;
  assign ld_valid  = in_vld_r && send;

  // keys_r: floor keys in [7:0], then up, down, mode, work
  assign ld_frame.start_byte = start_byte;
  assign ld_frame.device_id  = device_id;
  assign ld_frame.key_one    = {KeyFixed, keys_r[9], keys_r[8], keys_r[3:0]};
  assign ld_frame.key_two    = {KeyFixed, keys_r[11], keys_r[10], keys_r[7:4]};

  always_comb begin
    in_vld_nxt = in_vld_r;
    ticks_nxt  = ticks_r;
    if (advance) begin
      in_vld_nxt = 1'b0;
      ticks_nxt  = send ? '0 : ticks_inc;
    end
    if (in_tvalid && in_tready) begin
      in_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
      ticks_r  <= '0;
    end else begin
      in_vld_r <= in_vld_nxt;
      ticks_r  <= ticks_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      keys_r <= in_keys;
    end
  end

endmodule

// ----- src/pkfc_ser.sv -----
// frame serializer, one byte per beat, crc built as the bytes go out
module pkfc_ser import pkfc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ld_valid,
  output logic       ld_ready,
  input  frame_t     ld_frame,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_byte,
  output logic       out_tlast
);

  frame_t     frame_r;
  frame_pos_t pos_r, pos_nxt;
  logic       busy_r, busy_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       beat, load;

  assign out_tvalid = busy_r;
  assign out_tlast  = (pos_r == POS_CRC);
  assign beat       = out_tvalid && out_tready;
  assign ld_ready   = !busy_r || (beat && out_tlast);
  assign load       = ld_valid && ld_ready;

  always_comb begin
    case (pos_r)
      POS_START: out_byte = frame_r.start_byte;
      POS_DEV:   out_byte = frame_r.device_id;
      POS_KEY1:  out_byte = frame_r.key_one;
      POS_KEY2:  out_byte = frame_r.key_two;
      default:   out_byte = crc_r;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    if (load) begin
      busy_nxt = 1'b1;
      pos_nxt  = POS_START;
      crc_nxt  = CrcInit;
    end else if (beat) begin
      if (out_tlast) begin
        busy_nxt = 1'b0;
      end else begin
        pos_nxt = frame_pos_t'(pos_r + IdxW'(1));
        crc_nxt = crc8_byte(crc_r, out_byte);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pos_r  <= POS_START;
    end else begin
      busy_r <= busy_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    if (load) begin
      frame_r <= ld_frame;
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    ld_valid && ld_ready |=> out_tvalid && pos_r == POS_START)
    else $error("frame load did not start at the first byte");

  a_frame_unbroken: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("frame ended before its crc byte");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast && !ld_valid |=> !out_tvalid)
    else $error("serializer stayed busy after the last byte");

endmodule

// ----- src/periodic_key_frame_crc8_sender_unit.sv -----
// top level: configuration registers, tick stage and frame serializer
// Takes one key-state tick per beat; a tick that leaves the count at or below
// send_period is absorbed with no output. A tick that pushes the count past
// send_period emits a five-byte frame (start byte, device id, two key bytes,
// crc-8 poly 0x07) on five output beats with out_tlast on the crc byte; the
// tick waits in the input register until the serializer loads the frame, so
// a following sending tick waits there until the previous frame's last byte is
// taken. Configuration writes are always ready and are taken one per cycle.
module periodic_key_frame_crc8_sender_unit import pkfc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // floor_keys[7:0], key_up, key_down, key_mode, key_work
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [7:0]   out_tdata,  // frame_byte[7:0]
  output logic         out_tlast,  // frame_last
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [15:0]  cfg_data
);

  logic [7:0]         start_byte_r;
  logic [7:0]         device_id_r;
  logic [PeriodW-1:0] send_period_r;
  logic               ld_valid, ld_ready;
  frame_t             ld_frame;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_byte_r  <= '0;
      device_id_r   <= '0;
      send_period_r <= SendPeriodRst;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_START_BYTE:  start_byte_r  <= cfg_data[7:0];
        REG_DEVICE_ID:   device_id_r   <= cfg_data[7:0];
        REG_SEND_PERIOD: send_period_r <= cfg_data[PeriodW-1:0];
        default: ;
      endcase
    end
  end

  pkfc_tick u_tick (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_keys     (in_tdata[KeyW-1:0]),
    .start_byte  (start_byte_r),
    .device_id   (device_id_r),
    .send_period (send_period_r),
    .ld_valid    (ld_valid),
    .ld_ready    (ld_ready),
    .ld_frame    (ld_frame)
  );

  pkfc_ser u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .ld_valid   (ld_valid),
    .ld_ready   (ld_ready),
    .ld_frame   (ld_frame),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_byte   (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
